### sv/qaam_pkg.sv
// Shared types, constants and fixed-point helpers for the attitude/altitude mixer.
// Number format: signed Q16.16, saturating. No dependencies.
package qaam_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int GAIN_W = DATA_W - 1;
	localparam int SUM_W  = DATA_W + 4;
	localparam int MB_W   = FRAC_W + 2;
	localparam int PROD_W = DATA_W + MB_W - 1;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = ADDR_W - 2;

	localparam longint ONE_L = longint'(1) << FRAC_W;

	localparam logic [IDX_W-1:0] REG_ROLL_GAIN  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_PITCH_GAIN = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_ALT_GAIN   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_HOVER      = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_GROUND     = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_ALT_INC    = IDX_W'(5);

	localparam logic [1:0] KEY_NEG   = 2'd1;
	localparam logic [1:0] KEY_POS   = 2'd2;
	localparam logic [1:0] ALT_RAISE = 2'd1;
	localparam logic [1:0] ALT_LOWER = 2'd2;

	localparam logic signed [DATA_W-1:0] ROLL_MAG  = DATA_W'(ONE_L);
	localparam logic signed [DATA_W-1:0] PITCH_MAG = DATA_W'(2 * ONE_L);
	localparam logic signed [DATA_W-1:0] YAW_MAG   =
		DATA_W'(((longint'(13) << FRAC_W) + 5) / 10);

	localparam logic signed [MB_W-1:0] CAM_ROLL_K  =
		MB_W'(-(((longint'(115) << FRAC_W) + 500) / 1000));
	localparam logic signed [MB_W-1:0] CAM_PITCH_K =
		MB_W'(-(((longint'(1) << FRAC_W) + 5) / 10));

	localparam logic [GAIN_W-1:0] RST_ROLL_GAIN  = GAIN_W'(longint'(50) << FRAC_W);
	localparam logic [GAIN_W-1:0] RST_PITCH_GAIN = GAIN_W'(longint'(30) << FRAC_W);
	localparam logic [GAIN_W-1:0] RST_ALT_GAIN   = GAIN_W'(longint'(3) << FRAC_W);
	localparam logic [GAIN_W-1:0] RST_HOVER      =
		GAIN_W'(((longint'(685) << FRAC_W) + 5) / 10);
	localparam logic signed [DATA_W-1:0] RST_GROUND =
		DATA_W'(((longint'(6) << FRAC_W) + 5) / 10);
	localparam logic [GAIN_W-1:0] RST_ALT_INC    =
		GAIN_W'(((longint'(5) << FRAC_W) + 50) / 100);
	localparam logic signed [DATA_W-1:0] RST_HEIGHT = DATA_W'(ONE_L);

	localparam logic signed [SUM_W-1:0] SUM_MAX =
		{{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN =
		{{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(ONE_L);

	typedef struct packed {
		logic [GAIN_W-1:0]        roll_gain;
		logic [GAIN_W-1:0]        pitch_gain;
		logic [GAIN_W-1:0]        alt_gain;
		logic [GAIN_W-1:0]        hover;
		logic signed [DATA_W-1:0] ground;
		logic [GAIN_W-1:0]        alt_inc;
	} cfg_t;

	function automatic logic signed [SUM_W-1:0] ext_s(input logic signed [DATA_W-1:0] v);
		return SUM_W'(v);
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_u(input logic [GAIN_W-1:0] v);
		return $signed(SUM_W'(v));
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SUM_MAX)
			r = SUM_MAX[DATA_W-1:0];
		else if (v < SUM_MIN)
			r = SUM_MIN[DATA_W-1:0];
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic signed [MB_W-1:0] clamp_one(input logic signed [SUM_W-1:0] v);
		logic signed [MB_W-1:0] r;
		if (v > ONE_S)
			r = MB_W'(ONE_S);
		else if (v < -ONE_S)
			r = MB_W'(-ONE_S);
		else
			r = v[MB_W-1:0];
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] key_off(input logic [1:0] key,
			input logic signed [DATA_W-1:0] mag);
		logic signed [DATA_W-1:0] r;
		case (key)
			KEY_NEG: r = -mag;
			KEY_POS: r = mag;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### sv/qaam_cfg.sv
// APB-style configuration register file: gains, hover thrust, ground offset, step.
// Depends on qaam_pkg.
module qaam_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [qaam_pkg::ADDR_W-1:0]       paddr,
	input  logic [qaam_pkg::DATA_W-1:0]       pwdata,
	output logic [qaam_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	output qaam_pkg::cfg_t                    cfg
);

	localparam int DW = qaam_pkg::DATA_W;
	localparam int GW = qaam_pkg::GAIN_W;

	logic [qaam_pkg::IDX_W-1:0] idx;
	logic                       wr_en;
	qaam_pkg::cfg_t             cfg_q;

	assign idx    = paddr[qaam_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_gain  <= qaam_pkg::RST_ROLL_GAIN;
			cfg_q.pitch_gain <= qaam_pkg::RST_PITCH_GAIN;
			cfg_q.alt_gain   <= qaam_pkg::RST_ALT_GAIN;
			cfg_q.hover      <= qaam_pkg::RST_HOVER;
			cfg_q.ground     <= qaam_pkg::RST_GROUND;
			cfg_q.alt_inc    <= qaam_pkg::RST_ALT_INC;
		end else if (wr_en) begin
			case (idx)
				qaam_pkg::REG_ROLL_GAIN:  cfg_q.roll_gain  <= pwdata[GW-1:0];
				qaam_pkg::REG_PITCH_GAIN: cfg_q.pitch_gain <= pwdata[GW-1:0];
				qaam_pkg::REG_ALT_GAIN:   cfg_q.alt_gain   <= pwdata[GW-1:0];
				qaam_pkg::REG_HOVER:      cfg_q.hover      <= pwdata[GW-1:0];
				qaam_pkg::REG_GROUND:     cfg_q.ground     <= $signed(pwdata);
				qaam_pkg::REG_ALT_INC:    cfg_q.alt_inc    <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			qaam_pkg::REG_ROLL_GAIN:  prdata = DW'(cfg_q.roll_gain);
			qaam_pkg::REG_PITCH_GAIN: prdata = DW'(cfg_q.pitch_gain);
			qaam_pkg::REG_ALT_GAIN:   prdata = DW'(cfg_q.alt_gain);
			qaam_pkg::REG_HOVER:      prdata = DW'(cfg_q.hover);
			qaam_pkg::REG_GROUND:     prdata = cfg_q.ground;
			qaam_pkg::REG_ALT_INC:    prdata = DW'(cfg_q.alt_inc);
			default:                  prdata = '0;
		endcase
	end

endmodule

### sv/qaam_mul.sv
// Shared Q16.16 multiplier, 32 x 17 bit magnitude, with a registered product and a registered result.
// Rounds to nearest (ties away from zero), then applies sign and saturates. Uses qaam_pkg.
module qaam_mul (
	input  logic                                clk,
	input  logic signed [qaam_pkg::DATA_W-1:0]  a,
	input  logic signed [qaam_pkg::MB_W-1:0]    b,
	output logic signed [qaam_pkg::DATA_W-1:0]  res
);

	localparam int DW = qaam_pkg::DATA_W;
	localparam int BW = qaam_pkg::MB_W;
	localparam int PW = qaam_pkg::PROD_W;
	localparam int FW = qaam_pkg::FRAC_W;
	localparam int SW = qaam_pkg::SUM_W;
	localparam logic [PW-1:0] HALF = PW'(1) << (FW - 1);

	logic [DW-1:0]        ua;
	logic [BW-2:0]        ub;
	logic [PW-1:0]        prod_s1;
	logic                 neg_s1;
	logic [PW-1:0]        rsum;
	logic signed [SW-1:0] mag;
	logic signed [SW-1:0] sval;
	logic signed [DW-1:0] res_s2;

	always_comb begin
		ua = a[DW-1] ? DW'(-a) : DW'(a);
		ub = b[BW-1] ? (BW-1)'(-b) : (BW-1)'(b);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(ua) * PW'(ub);
		neg_s1  <= a[DW-1] ^ b[BW-1];
	end

	always_comb begin
		rsum = prod_s1 + HALF;
		mag  = SW'(rsum[PW-1:FW]);
		sval = neg_s1 ? -mag : mag;
	end

	always_ff @(posedge clk) begin
		res_s2 <= qaam_pkg::sat_d(sval);
	end

	assign res = res_s2;

endmodule

### sv/quadrotor_attitude_altitude_mixer_top.sv
// Quadrotor attitude/altitude controller and motor mixer, top level.
// Instantiates qaam_cfg and qaam_mul; uses qaam_pkg.
//
// One request is accepted when the block is idle; thirteen sequencer steps then run
// the seven products through one shared 32 x 17 multiplier and the four motor sums
// through one adder, and the result is held until taken. A new request is taken only
// after the result has been taken and the block has returned to idle.
module quadrotor_attitude_altitude_mixer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [qaam_pkg::ADDR_W-1:0]        paddr,
	input  logic [qaam_pkg::DATA_W-1:0]        pwdata,
	output logic [qaam_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic signed [qaam_pkg::DATA_W-1:0] roll_tilt,
	input  logic signed [qaam_pkg::DATA_W-1:0] pitch_tilt,
	input  logic signed [qaam_pkg::DATA_W-1:0] altitude,
	input  logic signed [qaam_pkg::DATA_W-1:0] roll_rate,
	input  logic signed [qaam_pkg::DATA_W-1:0] pitch_rate,
	input  logic [1:0]                         pitch_key,
	input  logic [1:0]                         yaw_key,
	input  logic [1:0]                         roll_key,
	input  logic [1:0]                         altitude_key,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [qaam_pkg::DATA_W-1:0] front_left_velocity,
	output logic signed [qaam_pkg::DATA_W-1:0] front_right_velocity,
	output logic signed [qaam_pkg::DATA_W-1:0] back_left_velocity,
	output logic signed [qaam_pkg::DATA_W-1:0] back_right_velocity,
	output logic signed [qaam_pkg::DATA_W-1:0] camera_roll_position,
	output logic signed [qaam_pkg::DATA_W-1:0] camera_pitch_position,
	output logic signed [qaam_pkg::DATA_W-1:0] target_altitude
);

	localparam int DW = qaam_pkg::DATA_W;
	localparam int BW = qaam_pkg::MB_W;
	localparam int SW = qaam_pkg::SUM_W;

	localparam logic [3:0] STP_HEIGHT  = 4'd0;
	localparam logic [3:0] STP_DIFF    = 4'd1;
	localparam logic [3:0] STP_ROLL    = 4'd2;
	localparam logic [3:0] STP_PITCH   = 4'd3;
	localparam logic [3:0] STP_CUBE    = 4'd4;
	localparam logic [3:0] STP_CAM_R   = 4'd5;
	localparam logic [3:0] STP_ALT     = 4'd6;
	localparam logic [3:0] STP_CAM_P   = 4'd7;
	localparam logic [3:0] STP_BASE    = 4'd8;
	localparam logic [3:0] STP_FL      = 4'd9;
	localparam logic [3:0] STP_FR      = 4'd10;
	localparam logic [3:0] STP_BL      = 4'd11;
	localparam logic [3:0] STP_BR      = 4'd12;
	localparam logic [3:0] STP_LAST    = STP_BR;

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DONE} state_t;

	state_t                state_q;
	logic [3:0]            step_q;
	logic signed [DW-1:0]  dh_q;
	qaam_pkg::cfg_t        cfg;
	logic                  req_acc;

	logic signed [DW-1:0]  roll_tilt_q, pitch_tilt_q, altitude_q;
	logic signed [DW-1:0]  roll_rate_q, pitch_rate_q;
	logic [1:0]            pitch_key_q, yaw_key_q, roll_key_q, alt_key_q;

	logic signed [BW-1:0]  d_q;
	logic signed [DW-1:0]  r_q, p_q, cam_r_q, cam_p_q;
	logic signed [SW-1:0]  base_q;
	logic signed [DW-1:0]  fl_q, fr_q, bl_q, br_q;

	logic signed [DW-1:0]  mul_a, mul_res;
	logic signed [BW-1:0]  mul_b;
	logic signed [DW-1:0]  yaw_cmd;
	logic                  neg_r, neg_p, neg_y, neg_out;
	logic signed [SW-1:0]  mix_sum;
	logic signed [DW-1:0]  mix_sat, mix_out;

	qaam_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qaam_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.res (mul_res)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign res_valid = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			dh_q    <= qaam_pkg::RST_HEIGHT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (req_acc)
						state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (step_q == STP_HEIGHT) begin
						case (alt_key_q)
							qaam_pkg::ALT_RAISE: dh_q <= qaam_pkg::sat_d(
								qaam_pkg::ext_s(dh_q) + qaam_pkg::ext_u(cfg.alt_inc));
							qaam_pkg::ALT_LOWER: dh_q <= qaam_pkg::sat_d(
								qaam_pkg::ext_s(dh_q) - qaam_pkg::ext_u(cfg.alt_inc));
							default: ;
						endcase
					end
					if (step_q == STP_LAST)
						state_q <= ST_DONE;
					else
						step_q <= step_q + 4'd1;
				end
				ST_DONE: begin
					if (!res_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared multiplier operands; each result is read once it has passed the multiplier's product and result registers
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_CALC) begin
			case (step_q)
				STP_HEIGHT: begin
					mul_a = $signed({1'b0, cfg.roll_gain});
					mul_b = qaam_pkg::clamp_one(qaam_pkg::ext_s(roll_tilt_q));
				end
				STP_DIFF: begin
					mul_a = $signed({1'b0, cfg.pitch_gain});
					mul_b = qaam_pkg::clamp_one(qaam_pkg::ext_s(pitch_tilt_q));
				end
				STP_ROLL: begin
					mul_a = DW'(d_q);
					mul_b = d_q;
				end
				STP_PITCH: begin
					mul_a = roll_rate_q;
					mul_b = qaam_pkg::CAM_ROLL_K;
				end
				STP_CUBE: begin
					mul_a = DW'(d_q);
					mul_b = mul_res[BW-1:0];
				end
				STP_CAM_R: begin
					mul_a = pitch_rate_q;
					mul_b = qaam_pkg::CAM_PITCH_K;
				end
				STP_ALT: begin
					mul_a = $signed({1'b0, cfg.alt_gain});
					mul_b = mul_res[BW-1:0];
				end
				default: ;
			endcase
		end
	end

	// motor mix: base +/- R +/- P +/- Y, right-front and left-back negated
	always_comb begin
		yaw_cmd = qaam_pkg::key_off(yaw_key_q, qaam_pkg::YAW_MAG);
		case (step_q)
			STP_FL:  {neg_r, neg_p, neg_y, neg_out} = 4'b1010;
			STP_FR:  {neg_r, neg_p, neg_y, neg_out} = 4'b0001;
			STP_BL:  {neg_r, neg_p, neg_y, neg_out} = 4'b1101;
			STP_BR:  {neg_r, neg_p, neg_y, neg_out} = 4'b0110;
			default: {neg_r, neg_p, neg_y, neg_out} = 4'b0000;
		endcase
		mix_sum = base_q
			+ (neg_r ? -qaam_pkg::ext_s(r_q) : qaam_pkg::ext_s(r_q))
			+ (neg_p ? -qaam_pkg::ext_s(p_q) : qaam_pkg::ext_s(p_q))
			+ (neg_y ? -qaam_pkg::ext_s(yaw_cmd) : qaam_pkg::ext_s(yaw_cmd));
		mix_sat = qaam_pkg::sat_d(mix_sum);
		mix_out = neg_out ? qaam_pkg::sat_d(-qaam_pkg::ext_s(mix_sat)) : mix_sat;
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			roll_tilt_q   <= roll_tilt;
			pitch_tilt_q  <= pitch_tilt;
			altitude_q    <= altitude;
			roll_rate_q   <= roll_rate;
			pitch_rate_q  <= pitch_rate;
			pitch_key_q   <= pitch_key;
			yaw_key_q     <= yaw_key;
			roll_key_q    <= roll_key;
			alt_key_q     <= altitude_key;
		end
		if (state_q == ST_CALC) begin
			case (step_q)
				STP_DIFF: d_q <= qaam_pkg::clamp_one(qaam_pkg::ext_s(dh_q)
					- qaam_pkg::ext_s(altitude_q) + qaam_pkg::ext_s(cfg.ground));
				STP_ROLL: r_q <= qaam_pkg::sat_d(qaam_pkg::ext_s(mul_res)
					+ qaam_pkg::ext_s(roll_rate_q)
					+ qaam_pkg::ext_s(qaam_pkg::key_off(roll_key_q, qaam_pkg::ROLL_MAG)));
				STP_PITCH: p_q <= qaam_pkg::sat_d(qaam_pkg::ext_s(mul_res)
					+ qaam_pkg::ext_s(pitch_rate_q)
					+ qaam_pkg::ext_s(qaam_pkg::key_off(pitch_key_q, qaam_pkg::PITCH_MAG)));
				STP_CAM_R: cam_r_q <= mul_res;
				STP_CAM_P: cam_p_q <= mul_res;
				STP_BASE:  base_q  <= qaam_pkg::ext_u(cfg.hover) + qaam_pkg::ext_s(mul_res);
				STP_FL:    fl_q    <= mix_out;
				STP_FR:    fr_q    <= mix_out;
				STP_BL:    bl_q    <= mix_out;
				STP_BR:    br_q    <= mix_out;
				default: ;
			endcase
		end
	end

	assign front_left_velocity   = fl_q;
	assign front_right_velocity  = fr_q;
	assign back_left_velocity    = bl_q;
	assign back_right_velocity   = br_q;
	assign camera_roll_position  = cam_r_q;
	assign camera_pitch_position = cam_p_q;
	assign target_altitude       = dh_q;

	a_no_take_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> !res_valid)
		else $error("request taken while a result is pending");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_CALC && step_q == STP_LAST))
		else $error("result shown before the last step");

	a_height_moves_once: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_CALC && step_q == STP_HEIGHT) |=> $stable(dh_q))
		else $error("target altitude changed outside its update step");

	a_diff_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC && step_q > STP_DIFF) |->
		(qaam_pkg::ext_s(DW'(d_q)) <= qaam_pkg::ONE_S &&
		 qaam_pkg::ext_s(DW'(d_q)) >= -qaam_pkg::ONE_S))
		else $error("altitude error outside plus or minus one");

endmodule
